// ===== rtl/mcsm_pkg.sv =====
// Shared types and constants for the motor current safety monitor.
// No dependencies; used by every module of the block.
package mcsm_pkg;

  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int HIT_W      = 16;
  localparam int GAIN_W     = 2;

  localparam int DEF_WINDOW        = 40;
  localparam int DEF_AVERAGES      = 3;
  localparam int DEF_NOLOAD_TRIP   = 5;
  localparam int DEF_OVERLOAD_TRIP = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOLOAD_THRESHOLD   = 3'd0,
    REG_BAND_ONE_LOW       = 3'd1,
    REG_BAND_ONE_HIGH      = 3'd2,
    REG_BAND_TWO_LOW       = 3'd3,
    REG_BAND_TWO_HIGH      = 3'd4,
    REG_BAND_THREE_LOW     = 3'd5,
    REG_OVERLOAD_THRESHOLD = 3'd6
  } cfg_reg_t;

  localparam logic signed [DATA_W-1:0] RST_NOLOAD_THRESHOLD   = 16'sd100;
  localparam logic signed [DATA_W-1:0] RST_BAND_ONE_LOW       = 16'sd300;
  localparam logic signed [DATA_W-1:0] RST_BAND_ONE_HIGH      = 16'sd400;
  localparam logic signed [DATA_W-1:0] RST_BAND_TWO_LOW       = 16'sd500;
  localparam logic signed [DATA_W-1:0] RST_BAND_TWO_HIGH      = 16'sd600;
  localparam logic signed [DATA_W-1:0] RST_BAND_THREE_LOW     = 16'sd700;
  localparam logic signed [DATA_W-1:0] RST_OVERLOAD_THRESHOLD = 16'sd800;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_NONE  = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_TWO   = 2'd2;
  localparam logic [GAIN_W-1:0] GAIN_THREE = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] noload_threshold;
    logic signed [DATA_W-1:0] band_one_low;
    logic signed [DATA_W-1:0] band_one_high;
    logic signed [DATA_W-1:0] band_two_low;
    logic signed [DATA_W-1:0] band_two_high;
    logic signed [DATA_W-1:0] band_three_low;
    logic signed [DATA_W-1:0] overload_threshold;
  } cfg_regs_t;

endpackage

// ===== rtl/mcsm_avg_div.sv =====
// Signed block sum divided by the window length, truncated toward zero.
// Uses mcsm_pkg; exact reciprocal multiply on the magnitude, then restore sign.
module mcsm_avg_div #(
  parameter int WINDOW = mcsm_pkg::DEF_WINDOW
) (
  input  logic signed [mcsm_pkg::DATA_W+$clog2(WINDOW)-1:0] sum,
  output logic signed [mcsm_pkg::DATA_W-1:0]                quotient
);
  import mcsm_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(WINDOW);
  localparam int MAG_W = SUM_W;
  localparam int SHIFT = MAG_W + $clog2(WINDOW);
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [MAG_W:0] RECIP_C = RECIP[MAG_W:0];
  localparam int PROD_W = 2 * MAG_W + 1;

  logic                negative;
  logic [MAG_W-1:0]    magnitude;
  logic [PROD_W-1:0]   product;
  logic [DATA_W:0]     quot_mag;
  logic [DATA_W:0]     quot_signed;

  always_comb begin
    negative    = sum[SUM_W-1];
    magnitude   = negative ? MAG_W'(-sum) : MAG_W'(sum);
    product     = PROD_W'(magnitude) * PROD_W'(RECIP_C);
    quot_mag    = product[SHIFT +: DATA_W+1];
    quot_signed = negative ? (DATA_W+1)'(-quot_mag) : quot_mag;
    quotient    = quot_signed[DATA_W-1:0];
  end

endmodule

// ===== rtl/motor_current_safety_monitor.sv =====
// An accepted item's result is registered; one item per cycle while in_stall is low.
// Each sample item passes through the running-sum adder, the reciprocal multiplier and
// the band compares into the result register; check items use the trip compares.
// A result waiting under out_stall holds in_stall high only while it blocks.
// Reset (rst, synchronous) clears sums, counters, averages, the stop latch and
// loads the threshold registers with their default values.
module motor_current_safety_monitor #(
  parameter int WINDOW        = mcsm_pkg::DEF_WINDOW,
  parameter int AVERAGES      = mcsm_pkg::DEF_AVERAGES,
  parameter int NOLOAD_TRIP   = mcsm_pkg::DEF_NOLOAD_TRIP,
  parameter int OVERLOAD_TRIP = mcsm_pkg::DEF_OVERLOAD_TRIP
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mcsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcsm_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic signed [mcsm_pkg::DATA_W-1:0]  current_sample,
  input  logic                                pid_enabled,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                average_valid,
  output logic signed [mcsm_pkg::DATA_W-1:0]  average_current,
  output logic                                max_valid,
  output logic signed [mcsm_pkg::DATA_W-1:0]  max_current,
  output logic [mcsm_pkg::GAIN_W-1:0]         gain_set,
  output logic                                noload_stop,
  output logic                                overload_stop,
  output logic                                stopped
);
  import mcsm_pkg::*;

  localparam int SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW);
  localparam int SLOT_W = (AVERAGES > 1) ? $clog2(AVERAGES) : 1;

  cfg_regs_t                 cfg;
  logic signed [SUM_W-1:0]   sample_sum;
  logic [CNT_W-1:0]          sample_count;
  logic [SLOT_W-1:0]         average_slot;
  logic signed [DATA_W-1:0]  ring_max;
  logic signed [DATA_W-1:0]  latest_average;
  logic [HIT_W-1:0]          noload_count;
  logic [HIT_W-1:0]          overload_count;
  logic                      stop_latched;

  logic                      accept;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [DATA_W-1:0]  block_avg;
  logic                      block_done;
  logic                      ring_last;
  logic signed [DATA_W-1:0]  ring_max_next;
  logic [GAIN_W-1:0]         gain_next;
  logic                      check_live;
  logic                      noload_hit;
  logic                      overload_hit;
  logic [HIT_W-1:0]          noload_count_next;
  logic [HIT_W-1:0]          overload_count_next;
  logic                      noload_trip;
  logic                      overload_trip;
  logic                      stop_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  mcsm_avg_div #(
    .WINDOW (WINDOW)
  ) u_avg_div (
    .sum      (sum_next),
    .quotient (block_avg)
  );

  always_comb begin
    sum_next   = sample_sum + SUM_W'(current_sample);
    block_done = (op == OP_SAMPLE) && (sample_count == CNT_W'(WINDOW - 1));
    ring_last  = (average_slot == SLOT_W'(AVERAGES - 1));

    if (average_slot == '0 || ring_max < block_avg) begin
      ring_max_next = block_avg;
    end else begin
      ring_max_next = ring_max;
    end

    gain_next = GAIN_NONE;
    if (pid_enabled) begin
      priority if (block_avg >= cfg.band_one_low && block_avg < cfg.band_one_high) begin
        gain_next = GAIN_ONE;
      end else if (block_avg >= cfg.band_two_low && block_avg < cfg.band_two_high) begin
        gain_next = GAIN_TWO;
      end else if (block_avg >= cfg.band_three_low
                   && block_avg < cfg.overload_threshold) begin
        gain_next = GAIN_THREE;
      end else begin
        gain_next = GAIN_NONE;
      end
    end

    check_live   = (op == OP_CHECK) && !stop_latched;
    noload_hit   = latest_average < cfg.noload_threshold;
    overload_hit = latest_average > cfg.overload_threshold;

    if (!noload_hit) begin
      noload_count_next = '0;
    end else if (noload_count == '1) begin
      noload_count_next = noload_count;
    end else begin
      noload_count_next = noload_count + 1'b1;
    end

    if (!overload_hit) begin
      overload_count_next = '0;
    end else if (overload_count == '1) begin
      overload_count_next = overload_count;
    end else begin
      overload_count_next = overload_count + 1'b1;
    end

    noload_trip   = check_live && noload_hit
                    && (noload_count_next == HIT_W'(NOLOAD_TRIP));
    overload_trip = check_live && overload_hit
                    && (overload_count_next == HIT_W'(OVERLOAD_TRIP));
    stop_next     = stop_latched || noload_trip || overload_trip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noload_threshold   <= RST_NOLOAD_THRESHOLD;
      cfg.band_one_low       <= RST_BAND_ONE_LOW;
      cfg.band_one_high      <= RST_BAND_ONE_HIGH;
      cfg.band_two_low       <= RST_BAND_TWO_LOW;
      cfg.band_two_high      <= RST_BAND_TWO_HIGH;
      cfg.band_three_low     <= RST_BAND_THREE_LOW;
      cfg.overload_threshold <= RST_OVERLOAD_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NOLOAD_THRESHOLD:   cfg.noload_threshold   <= cfg_data;
        REG_BAND_ONE_LOW:       cfg.band_one_low       <= cfg_data;
        REG_BAND_ONE_HIGH:      cfg.band_one_high      <= cfg_data;
        REG_BAND_TWO_LOW:       cfg.band_two_low       <= cfg_data;
        REG_BAND_TWO_HIGH:      cfg.band_two_high      <= cfg_data;
        REG_BAND_THREE_LOW:     cfg.band_three_low     <= cfg_data;
        REG_OVERLOAD_THRESHOLD: cfg.overload_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum     <= '0;
      sample_count   <= '0;
      average_slot   <= '0;
      ring_max       <= '0;
      latest_average <= '0;
      noload_count   <= '0;
      overload_count <= '0;
      stop_latched   <= 1'b0;
    end else if (accept) begin
      if (op == OP_SAMPLE) begin
        if (block_done) begin
          sample_sum     <= '0;
          sample_count   <= '0;
          latest_average <= block_avg;
          ring_max       <= ring_max_next;
          average_slot   <= ring_last ? '0 : average_slot + 1'b1;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= sample_count + 1'b1;
        end
      end else if (check_live) begin
        noload_count   <= noload_count_next;
        overload_count <= overload_count_next;
        stop_latched   <= stop_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      average_valid   <= block_done;
      average_current <= block_done ? block_avg : latest_average;
      max_valid       <= block_done && ring_last;
      max_current     <= (block_done && ring_last) ? ring_max_next : '0;
      gain_set        <= block_done ? gain_next : GAIN_NONE;
      noload_stop     <= noload_trip;
      overload_stop   <= overload_trip;
      stopped         <= stop_next;
    end
  end

endmodule

// ===== rtl/mcsm_checker.sv =====
// Port-level checks for the motor current safety monitor, bound to the top level.
// Depends on mcsm_pkg for widths only.
module mcsm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                average_valid,
  input logic signed [mcsm_pkg::DATA_W-1:0]  average_current,
  input logic                                max_valid,
  input logic [mcsm_pkg::GAIN_W-1:0]         gain_set,
  input logic                                noload_stop,
  input logic                                overload_stop,
  input logic                                stopped
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && stopped |=> !out_valid || stopped)
    else $error("stop latch released without reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (noload_stop || overload_stop) |-> stopped
      && !average_valid && gain_set == '0)
    else $error("trip reported without stop or on a sample item");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (max_valid || gain_set != '0) |-> average_valid)
    else $error("max or gain reported without a new average");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average_current))
    else $error("stalled result changed");

endmodule

bind motor_current_safety_monitor mcsm_checker u_mcsm_checker (.*);
